// ===== src/mlt_pkg.sv =====
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types, constants and character helpers of the mini language tokenizer.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int FIELD_W     = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};
    localparam logic [FIELD_W-1:0]     LIMIT_RESET = FIELD_W'(128);

    // Character codes.
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_VTAB     = 8'h0B;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LESS     = 8'h3C;
    localparam logic [7:0] CH_EQUALS   = 8'h3D;
    localparam logic [7:0] CH_GREATER  = 8'h3E;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_E  = 8'h65;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_LOWER_I  = 8'h69;
    localparam logic [7:0] CH_LOWER_L  = 8'h6C;
    localparam logic [7:0] CH_LOWER_N  = 8'h6E;
    localparam logic [7:0] CH_LOWER_P  = 8'h70;
    localparam logic [7:0] CH_LOWER_R  = 8'h72;
    localparam logic [7:0] CH_LOWER_S  = 8'h73;
    localparam logic [7:0] CH_LOWER_T  = 8'h74;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    typedef enum logic [1:0] {
        ST_TOKEN   = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_LIMIT   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        KIND_IDENT     = 4'd0,
        KIND_NUMBER    = 4'd1,
        KIND_KEYWORD   = 4'd2,
        KIND_OPERATOR  = 4'd3,
        KIND_ASSIGN    = 4'd4,
        KIND_SEMICOLON = 4'd5,
        KIND_LPAREN    = 4'd6,
        KIND_RPAREN    = 4'd7,
        KIND_LBRACE    = 4'd8,
        KIND_RBRACE    = 4'd9,
        KIND_COMPARE   = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        KWID_NONE  = 2'd0,
        KWID_PRINT = 2'd1,
        KWID_IF    = 2'd2,
        KWID_ELSE  = 2'd3
    } keyword_t;

    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_IDENT  = 2'd1,
        PEND_NUMBER = 2'd2,
        PEND_EQ     = 2'd3
    } pend_t;

    typedef enum logic [3:0] {
        KW_NONE  = 4'd0,
        KW_P     = 4'd1,
        KW_PR    = 4'd2,
        KW_PRI   = 4'd3,
        KW_PRIN  = 4'd4,
        KW_PRINT = 4'd5,
        KW_I     = 4'd6,
        KW_IF    = 4'd7,
        KW_E     = 4'd8,
        KW_EL    = 4'd9,
        KW_ELS   = 4'd10,
        KW_ELSE  = 4'd11
    } kw_state_t;

    typedef enum logic [3:0] {
        CC_LETTER,
        CC_DIGIT,
        CC_NEWLINE,
        CC_BLANK,
        CC_EQ,
        CC_OPER,
        CC_SEMI,
        CC_LPAREN,
        CC_RPAREN,
        CC_LBRACE,
        CC_RBRACE,
        CC_UNKNOWN
    } char_class_t;

    typedef struct packed {
        status_t             status;
        kind_t               token_kind;
        keyword_t            keyword_id;
        logic [7:0]          symbol;
        logic [FIELD_W-1:0]  token_start;
        logic [FIELD_W-1:0]  token_length;
        logic [FIELD_W-1:0]  line;
        logic                last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic char_class_t char_class(input logic [7:0] c);
        char_class_t cls;
        case (c) inside
            [CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z]: cls = CC_LETTER;
            [CH_ZERO:CH_NINE]:                                cls = CC_DIGIT;
            CH_NEWLINE:                                       cls = CC_NEWLINE;
            CH_SPACE, CH_TAB, [CH_VTAB:CH_CR]:                cls = CC_BLANK;
            CH_EQUALS:                                        cls = CC_EQ;
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LESS, CH_GREATER:
                                                              cls = CC_OPER;
            CH_SEMI:                                          cls = CC_SEMI;
            CH_LPAREN:                                        cls = CC_LPAREN;
            CH_RPAREN:                                        cls = CC_RPAREN;
            CH_LBRACE:                                        cls = CC_LBRACE;
            CH_RBRACE:                                        cls = CC_RBRACE;
            default:                                          cls = CC_UNKNOWN;
        endcase
        return cls;
    endfunction

    function automatic kw_state_t kw_begin(input logic [7:0] c);
        kw_state_t s;
        case (c)
            CH_LOWER_P: s = KW_P;
            CH_LOWER_I: s = KW_I;
            CH_LOWER_E: s = KW_E;
            default:    s = KW_NONE;
        endcase
        return s;
    endfunction

    function automatic kw_state_t kw_next(input kw_state_t s, input logic [7:0] c);
        kw_state_t n;
        n = KW_NONE;
        case (s)
            KW_P:    if (c == CH_LOWER_R) n = KW_PR;
            KW_PR:   if (c == CH_LOWER_I) n = KW_PRI;
            KW_PRI:  if (c == CH_LOWER_N) n = KW_PRIN;
            KW_PRIN: if (c == CH_LOWER_T) n = KW_PRINT;
            KW_I:    if (c == CH_LOWER_F) n = KW_IF;
            KW_E:    if (c == CH_LOWER_L) n = KW_EL;
            KW_EL:   if (c == CH_LOWER_S) n = KW_ELS;
            KW_ELS:  if (c == CH_LOWER_E) n = KW_ELSE;
            default: n = KW_NONE;
        endcase
        return n;
    endfunction

    function automatic keyword_t kw_id(input kw_state_t s);
        keyword_t k;
        case (s)
            KW_PRINT: k = KWID_PRINT;
            KW_IF:    k = KWID_IF;
            KW_ELSE:  k = KWID_ELSE;
            default:  k = KWID_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== src/mlt_if.sv =====
// ----------------------------------------------------------------------------
// mlt_if
// Valid/ready stream interfaces for source characters and result tokens.
// ----------------------------------------------------------------------------
interface mlt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_source;

    modport source (output valid, output character, output end_of_source, input ready);
    modport sink   (input valid, input character, input end_of_source, output ready);
endinterface

interface mlt_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [3:0]                  token_kind;
    logic [1:0]                  keyword_id;
    logic [7:0]                  symbol;
    logic [mlt_pkg::FIELD_W-1:0] token_start;
    logic [mlt_pkg::FIELD_W-1:0] token_length;
    logic [mlt_pkg::FIELD_W-1:0] line;
    logic                        last_of_run;

    modport source (
        output valid, output status, output token_kind, output keyword_id,
        output symbol, output token_start, output token_length, output line,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input status, input token_kind, input keyword_id,
        input symbol, input token_start, input token_length, input line,
        input last_of_run, output ready
    );
endinterface

// ===== src/mini_language_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// mini_language_tokenizer_top
// Streaming tokenizer: source characters in, tokens and error results out.
//
//   Channel   Direction  Beat contents
//   chars     in         character, end_of_source
//   tokens    out        status, token_kind, keyword_id, symbol, token_start,
//                        token_length, line, last_of_run
//   cfg       in         token_limit write (cfg_we, cfg_wdata)
//
// One character is taken per cycle while the result queue has room. It is
// decided from the input register, and its results go into the result queue.
// A character that makes two results holds the queue for two output beats, so
// a run of such characters is paced by the output beats.
// A character leaves the input register only while the four-entry result queue
// has room for two; otherwise the input register holds it and the input stalls.
// Reset clears the scanner state and sets token_limit to 128; no clearing pass.
// ----------------------------------------------------------------------------
module mini_language_tokenizer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    mlt_in_if.sink                      chars,
    mlt_out_if.source                   tokens,
    input  logic                        cfg_we,
    input  logic [mlt_pkg::FIELD_W-1:0] cfg_wdata
);
    import mlt_pkg::*;

    push_t push;
    logic  room;

    mlt_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .room      (room),
        .push      (push)
    );

    mlt_out_fifo u_out_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .tokens (tokens)
    );

endmodule

// ===== src/mlt_lexer.sv =====
// ----------------------------------------------------------------------------
// mlt_lexer
// Input register, scanner state and the single-pass token decision for one
// character, producing up to two results per character.
// ----------------------------------------------------------------------------
module mlt_lexer (
    input  logic                        clk,
    input  logic                        rst_n,
    mlt_in_if.sink                      chars,
    input  logic                        cfg_we,
    input  logic [mlt_pkg::FIELD_W-1:0] cfg_wdata,
    input  logic                        room,
    output mlt_pkg::push_t              push
);
    import mlt_pkg::*;

    typedef struct packed {
        logic                   present;
        logic                   is_error;
        kind_t                  kind;
        keyword_t               kw;
        logic [7:0]             symbol;
        logic [COUNT_WIDTH-1:0] start;
        logic [COUNT_WIDTH-1:0] len;
    } event_t;

    logic                   in_valid_reg;
    logic [7:0]             char_reg;
    logic                   eos_reg;
    logic [FIELD_W-1:0]     limit_reg;
    pend_t                  pend_reg, pend_next;
    kw_state_t              kw_reg, kw_next_st;
    logic [COUNT_WIDTH-1:0] start_reg, start_next;
    logic [COUNT_WIDTH-1:0] len_reg, len_next;
    logic [COUNT_WIDTH-1:0] position_reg;
    logic [COUNT_WIDTH-1:0] line_reg, line_next;
    logic [COUNT_WIDTH-1:0] tokens_reg, tokens_next;

    logic                   commit;
    char_class_t            cc;
    logic                   ext_id, ext_num, cmp, extend, done;
    logic [COUNT_WIDTH-1:0] len_inc;
    kw_state_t              kw_ext;
    event_t                 ev1, ev2;
    logic                   hit1, hit2;
    logic [COUNT_WIDTH-1:0] tokens_mid;
    result_t                res1, res2;

    assign commit      = in_valid_reg && room;
    assign chars.ready = !in_valid_reg || commit;

    always_comb
    begin
        cc      = char_class(char_reg);
        ext_id  = (pend_reg == PEND_IDENT) && (cc == CC_LETTER || cc == CC_DIGIT);
        ext_num = (pend_reg == PEND_NUMBER) && (cc == CC_DIGIT);
        cmp     = (pend_reg == PEND_EQ) && (cc == CC_EQ);
        extend  = ext_id || ext_num;
        done    = extend || cmp;
        len_inc = (len_reg < COUNT_MAX) ? len_reg + 1'b1 : len_reg;
        kw_ext  = ext_id ? kw_next(kw_reg, char_reg) : kw_reg;

        // Compare token, the pending token ended by this character, or it extended and flushed.
        ev1          = '0;
        ev1.kind     = KIND_IDENT;
        ev1.kw       = KWID_NONE;
        ev1.start    = start_reg;
        ev1.len      = len_reg;
        if (cmp)
        begin
            ev1.present = 1'b1;
            ev1.kind    = KIND_COMPARE;
            ev1.len     = COUNT_WIDTH'(2);
        end
        else if (!done)
        begin
            case (pend_reg)
                PEND_IDENT:
                begin
                    ev1.present = 1'b1;
                    ev1.kw      = kw_id(kw_reg);
                    ev1.kind    = (kw_id(kw_reg) != KWID_NONE) ? KIND_KEYWORD : KIND_IDENT;
                end
                PEND_NUMBER:
                begin
                    ev1.present = 1'b1;
                    ev1.kind    = KIND_NUMBER;
                end
                PEND_EQ:
                begin
                    ev1.present = 1'b1;
                    ev1.kind    = KIND_ASSIGN;
                    ev1.len     = COUNT_WIDTH'(1);
                end
                default:
                begin
                    ev1.present = 1'b0;
                end
            endcase
        end
        else if (extend && eos_reg)
        begin
            ev1.present = 1'b1;
            ev1.len     = len_inc;
            if (ext_id)
            begin
                ev1.kw   = kw_id(kw_ext);
                ev1.kind = (kw_id(kw_ext) != KWID_NONE) ? KIND_KEYWORD : KIND_IDENT;
            end
            else
            begin
                ev1.kind = KIND_NUMBER;
            end
        end

        // Result of the character itself.
        ev2       = '0;
        ev2.kind  = KIND_IDENT;
        ev2.kw    = KWID_NONE;
        ev2.start = position_reg;
        ev2.len   = COUNT_WIDTH'(1);
        if (!done)
        begin
            case (cc)
                CC_OPER:
                begin
                    ev2.present = 1'b1;
                    ev2.kind    = KIND_OPERATOR;
                    ev2.symbol  = char_reg;
                end
                CC_SEMI:
                begin
                    ev2.present = 1'b1;
                    ev2.kind    = KIND_SEMICOLON;
                end
                CC_LPAREN:
                begin
                    ev2.present = 1'b1;
                    ev2.kind    = KIND_LPAREN;
                end
                CC_RPAREN:
                begin
                    ev2.present = 1'b1;
                    ev2.kind    = KIND_RPAREN;
                end
                CC_LBRACE:
                begin
                    ev2.present = 1'b1;
                    ev2.kind    = KIND_LBRACE;
                end
                CC_RBRACE:
                begin
                    ev2.present = 1'b1;
                    ev2.kind    = KIND_RBRACE;
                end
                CC_UNKNOWN:
                begin
                    ev2.present  = 1'b1;
                    ev2.is_error = 1'b1;
                    ev2.symbol   = char_reg;
                end
                CC_LETTER:
                begin
                    ev2.present = eos_reg;
                end
                CC_DIGIT:
                begin
                    ev2.present = eos_reg;
                    ev2.kind    = KIND_NUMBER;
                end
                CC_EQ:
                begin
                    ev2.present = eos_reg;
                    ev2.kind    = KIND_ASSIGN;
                end
                default:
                begin
                    ev2.present = 1'b0;
                end
            endcase
        end

        // Token limit, checked in order for each token.
        hit1        = 32'(tokens_reg) >= 32'(limit_reg);
        tokens_mid  = tokens_reg + COUNT_WIDTH'(ev1.present && !hit1);
        hit2        = 32'(tokens_mid) >= 32'(limit_reg);
        tokens_next = tokens_mid + COUNT_WIDTH'(ev2.present && !ev2.is_error && !hit2);

        res1.status       = hit1 ? ST_LIMIT : ST_TOKEN;
        res1.token_kind   = ev1.kind;
        res1.keyword_id   = ev1.kw;
        res1.symbol       = ev1.symbol;
        res1.token_start  = FIELD_W'(ev1.start);
        res1.token_length = FIELD_W'(ev1.len);
        res1.line         = FIELD_W'(line_reg);
        res1.last_of_run  = !ev2.present;

        res2.status       = ev2.is_error ? ST_UNKNOWN : (hit2 ? ST_LIMIT : ST_TOKEN);
        res2.token_kind   = ev2.kind;
        res2.keyword_id   = ev2.kw;
        res2.symbol       = ev2.symbol;
        res2.token_start  = FIELD_W'(ev2.start);
        res2.token_length = FIELD_W'(ev2.len);
        res2.line         = FIELD_W'(line_reg);
        res2.last_of_run  = 1'b1;

        push.n      = commit ? (2'(ev1.present) + 2'(ev2.present)) : 2'd0;
        push.first  = ev1.present ? res1 : res2;
        push.second = res2;

        // Scanner state after this character.
        pend_next  = pend_reg;
        kw_next_st = kw_reg;
        start_next = start_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        if (extend)
        begin
            kw_next_st = kw_ext;
            len_next   = len_inc;
        end
        else if (cmp)
        begin
            pend_next = PEND_NONE;
        end
        else
        begin
            pend_next  = PEND_NONE;
            kw_next_st = KW_NONE;
            len_next   = '0;
            case (cc)
                CC_NEWLINE:
                begin
                    if (line_reg < COUNT_MAX)
                    begin
                        line_next = line_reg + 1'b1;
                    end
                end
                CC_LETTER:
                begin
                    pend_next  = PEND_IDENT;
                    start_next = position_reg;
                    len_next   = COUNT_WIDTH'(1);
                    kw_next_st = kw_begin(char_reg);
                end
                CC_DIGIT:
                begin
                    pend_next  = PEND_NUMBER;
                    start_next = position_reg;
                    len_next   = COUNT_WIDTH'(1);
                end
                CC_EQ:
                begin
                    pend_next  = PEND_EQ;
                    start_next = position_reg;
                    len_next   = COUNT_WIDTH'(1);
                end
                default:
                begin
                    pend_next = PEND_NONE;
                end
            endcase
        end
        if (eos_reg)
        begin
            pend_next  = PEND_NONE;
            kw_next_st = KW_NONE;
            len_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            limit_reg    <= LIMIT_RESET;
            pend_reg     <= PEND_NONE;
            kw_reg       <= KW_NONE;
            start_reg    <= '0;
            len_reg      <= '0;
            position_reg <= '0;
            line_reg     <= COUNT_WIDTH'(1);
            tokens_reg   <= '0;
        end
        else
        begin
            if (chars.ready)
            begin
                in_valid_reg <= chars.valid;
            end
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (commit)
            begin
                pend_reg     <= pend_next;
                kw_reg       <= kw_next_st;
                start_reg    <= start_next;
                len_reg      <= len_next;
                position_reg <= position_reg + 1'b1;
                line_reg     <= line_next;
                tokens_reg   <= tokens_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            char_reg <= chars.character;
            eos_reg  <= chars.end_of_source;
        end
    end

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        commit && eos_reg |=> pend_reg == PEND_NONE)
        else $error("pending token survived the last character");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(position_reg) && $stable(tokens_reg) && $stable(line_reg))
        else $error("scanner state moved without a committed character");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> push.second.last_of_run && !push.first.last_of_run)
        else $error("last_of_run misplaced on a two-result character");

endmodule

// ===== src/mlt_out_fifo.sv =====
// ----------------------------------------------------------------------------
// mlt_out_fifo
// Small result queue that takes up to two results per cycle and hands out one
// result beat per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module mlt_out_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  mlt_pkg::push_t push,
    output logic           room,
    mlt_out_if.source      tokens
);
    import mlt_pkg::*;

    result_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg;
    logic                   pop;
    result_t                head;

    assign room = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign pop  = tokens.valid && tokens.ready;
    assign head = mem[rd_ptr_reg];

    assign tokens.valid        = count_reg != '0;
    assign tokens.status       = head.status;
    assign tokens.token_kind   = head.token_kind;
    assign tokens.keyword_id   = head.keyword_id;
    assign tokens.symbol       = head.symbol;
    assign tokens.token_start  = head.token_start;
    assign tokens.token_length = head.token_length;
    assign tokens.line         = head.line;
    assign tokens.last_of_run  = head.last_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(push.n);
            rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(pop);
            count_reg  <= count_reg + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.n == 2'd2)
        begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2))
        else $error("results pushed into a queue without room");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == FIFO_CNT_W'($past(count_reg) + FIFO_CNT_W'($past(push.n))
                                          - FIFO_CNT_W'($past(pop))))
        else $error("queue occupancy lost track of pushes and pops");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mini language tokenizer. Source characters are
// fed beat by beat. A scoreboard class follows the scanner state and queues
// the tokens that each accepted character should produce. Every token beat is
// compared field by field with the oldest queued token. The run covers
// directed text, random statement-like text with noise, several token limits,
// back-pressure, and a long identifier followed by a few blank lines.
// ----------------------------------------------------------------------------
module testbench;
    import mlt_pkg::*;

    localparam int STALL_LIMIT = 2000;

    class lexer_scoreboard;
        logic [FIELD_W-1:0] limit;
        pend_t              held_kind;
        logic [47:0]        held_word;
        logic [FIELD_W-1:0] held_start;
        logic [FIELD_W-1:0] held_len;
        logic [FIELD_W-1:0] pos;
        logic [FIELD_W-1:0] line_no;
        logic [FIELD_W-1:0] emitted;
        result_t            expected_tokens[$];
        result_t            fresh[$];
        int                 errors;

        function new();
            limit      = LIMIT_RESET;
            held_kind  = PEND_NONE;
            held_word  = '0;
            held_start = '0;
            held_len   = '0;
            pos        = '0;
            line_no    = FIELD_W'(1);
            emitted    = '0;
            errors     = 0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function void emit(status_t st, kind_t kind, keyword_t kw, logic [7:0] sym,
                           logic [FIELD_W-1:0] start, logic [FIELD_W-1:0] len);
            result_t r;
            r.status       = st;
            r.token_kind   = kind;
            r.keyword_id   = kw;
            r.symbol       = sym;
            r.token_start  = start;
            r.token_length = len;
            r.line         = line_no;
            r.last_of_run  = 1'b0;
            fresh.push_back(r);
        endfunction

        function void score_token(kind_t kind, keyword_t kw, logic [7:0] sym,
                                  logic [FIELD_W-1:0] start, logic [FIELD_W-1:0] len);
            if (emitted >= limit)
            begin
                emit(ST_LIMIT, kind, kw, sym, start, len);
            end
            else
            begin
                emitted++;
                emit(ST_TOKEN, kind, kw, sym, start, len);
            end
        endfunction

        function keyword_t word_id();
            if (held_word == "print")
                return KWID_PRINT;
            if (held_word == "if")
                return KWID_IF;
            if (held_word == "else")
                return KWID_ELSE;
            return KWID_NONE;
        endfunction

        function void start_held(pend_t kind, logic [7:0] c, logic [FIELD_W-1:0] here);
            held_kind  = kind;
            held_start = here;
            held_len   = FIELD_W'(1);
            held_word  = {40'd0, c};
        endfunction

        function void grow(logic [7:0] c);
            if (held_len < 6)
                held_word = {held_word[39:0], c};
            if (held_len != COUNT_MAX)
                held_len++;
        endfunction

        function void flush_held();
            keyword_t kw;
            kw = word_id();
            case (held_kind)
                PEND_IDENT:
                begin
                    if (kw == KWID_NONE)
                        score_token(KIND_IDENT, kw, 8'd0, held_start, held_len);
                    else
                        score_token(KIND_KEYWORD, kw, 8'd0, held_start, held_len);
                end
                PEND_NUMBER: score_token(KIND_NUMBER, KWID_NONE, 8'd0, held_start, held_len);
                PEND_EQ:     score_token(KIND_ASSIGN, KWID_NONE, 8'd0, held_start, 16'd1);
                default:
                begin
                end
            endcase
            held_kind = PEND_NONE;
            held_len  = '0;
            held_word = '0;
        endfunction

        function void note_char(logic [7:0] c, logic eos);
            logic [FIELD_W-1:0] here;
            bit                 done;
            fresh.delete();
            here = pos;
            done = 1'b0;
            if (held_kind == PEND_IDENT && (is_letter(c) || is_digit(c)))
            begin
                grow(c);
                done = 1'b1;
            end
            else if (held_kind == PEND_NUMBER && is_digit(c))
            begin
                grow(c);
                done = 1'b1;
            end
            else if (held_kind == PEND_EQ && c == CH_EQUALS)
            begin
                held_kind = PEND_NONE;
                score_token(KIND_COMPARE, KWID_NONE, 8'd0, held_start, 16'd2);
                done = 1'b1;
            end
            if (!done)
            begin
                flush_held();
                if (c == CH_NEWLINE)
                begin
                    if (line_no != COUNT_MAX)
                        line_no++;
                end
                else if (is_blank(c))
                begin
                end
                else if (is_letter(c))
                    start_held(PEND_IDENT, c, here);
                else if (is_digit(c))
                    start_held(PEND_NUMBER, c, here);
                else if (c == CH_EQUALS)
                    start_held(PEND_EQ, c, here);
                else
                begin
                    case (c)
                        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LESS, CH_GREATER:
                            score_token(KIND_OPERATOR, KWID_NONE, c, here, 16'd1);
                        CH_SEMI:   score_token(KIND_SEMICOLON, KWID_NONE, 8'd0, here, 16'd1);
                        CH_LPAREN: score_token(KIND_LPAREN, KWID_NONE, 8'd0, here, 16'd1);
                        CH_RPAREN: score_token(KIND_RPAREN, KWID_NONE, 8'd0, here, 16'd1);
                        CH_LBRACE: score_token(KIND_LBRACE, KWID_NONE, 8'd0, here, 16'd1);
                        CH_RBRACE: score_token(KIND_RBRACE, KWID_NONE, 8'd0, here, 16'd1);
                        default:   emit(ST_UNKNOWN, KIND_IDENT, KWID_NONE, c, here, 16'd1);
                    endcase
                end
            end
            if (eos)
                flush_held();
            pos++;
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last_of_run = 1'b1;
            foreach (fresh[i])
                expected_tokens.push_back(fresh[i]);
        endfunction

        function void compare(string name, int unsigned want_v, int unsigned got_v);
            if (want_v != got_v)
            begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
            end
        endfunction

        function void check_token(result_t got);
            result_t want;
            if (expected_tokens.size() == 0)
            begin
                errors++;
                $display("%0t: token beat with nothing expected, expected none actual %h",
                         $time, got);
                return;
            end
            want = expected_tokens.pop_front();
            compare("status", want.status, got.status);
            compare("token_kind", want.token_kind, got.token_kind);
            compare("keyword_id", want.keyword_id, got.keyword_id);
            compare("symbol", want.symbol, got.symbol);
            compare("token_start", want.token_start, got.token_start);
            compare("token_length", want.token_length, got.token_length);
            compare("line", want.line, got.line);
            compare("last_of_run", want.last_of_run, got.last_of_run);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [FIELD_W-1:0] cfg_wdata;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_cycles;
    logic [7:0]         source_text[$];
    lexer_scoreboard    lexer = new();

    string      word_list[9]     = '{"print", "if", "else", "pri", "els", "iff", "printf",
                                     "i", "If"};
    logic [7:0] operator_list[6] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LESS, CH_GREATER};
    logic [7:0] punct_list[5]    = '{CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE};
    logic [7:0] space_list[6]    = '{CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB, 8'h0C, CH_CR};

    mlt_in_if  chars_if ();
    mlt_out_if tokens_if ();

    mini_language_tokenizer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .tokens    (tokens_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] rand_letter();
        int v;
        v = $urandom_range(0, 51);
        if (v < 26)
            return CH_LOWER_A + 8'(v);
        return CH_UPPER_A + 8'(v - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int v;
        v = $urandom_range(0, 61);
        if (v < 10)
            return CH_ZERO + 8'(v);
        return rand_letter();
    endfunction

    function automatic void push_word(input string s);
        for (int i = 0; i < s.len(); i++)
            source_text.push_back(s[i]);
    endfunction

    function automatic void refill_source();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            source_text.push_back(8'($urandom_range(0, 255)));
        else if (pick < 30)
        begin
            if ($urandom_range(0, 2) == 0)
                push_word(word_list[$urandom_range(0, 8)]);
            else
            begin
                source_text.push_back(rand_letter());
                n = $urandom_range(0, 7);
                repeat (n) source_text.push_back(rand_alnum());
            end
        end
        else if (pick < 45)
        begin
            n = $urandom_range(1, 5);
            repeat (n) source_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (pick < 52)
            source_text.push_back(CH_EQUALS);
        else if (pick < 58)
            push_word("==");
        else if (pick < 70)
            source_text.push_back(operator_list[$urandom_range(0, 5)]);
        else if (pick < 85)
            source_text.push_back(punct_list[$urandom_range(0, 4)]);
        else
            source_text.push_back(space_list[$urandom_range(0, 5)]);
        if ($urandom_range(0, 1) == 0)
            source_text.push_back(CH_SPACE);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eos);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        chars_if.valid         <= 1'b1;
        chars_if.character     <= c;
        chars_if.end_of_source <= eos;
        do @(posedge clk); while (!chars_if.ready);
        lexer.note_char(c, eos);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    task automatic send_random(input int count);
        logic [7:0] c;
        repeat (count)
        begin
            if (source_text.size() == 0)
                refill_source();
            c = source_text.pop_front();
            send_char(c, $urandom_range(0, 99) < 3);
        end
    endtask

    task automatic settle();
        chars_if.valid <= 1'b0;
        while (lexer.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [FIELD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        lexer.limit = value;
    endtask

    initial
    begin
        result_t got;
        tokens_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && tokens_if.valid && tokens_if.ready)
            begin
                got.status       = status_t'(tokens_if.status);
                got.token_kind   = kind_t'(tokens_if.token_kind);
                got.keyword_id   = keyword_t'(tokens_if.keyword_id);
                got.symbol       = tokens_if.symbol;
                got.token_start  = tokens_if.token_start;
                got.token_length = tokens_if.token_length;
                got.line         = tokens_if.line;
                got.last_of_run  = tokens_if.last_of_run;
                lexer.check_token(got);
            end
            if (hold_cycles > 0)
            begin
                tokens_if.ready <= 1'b0;
                hold_cycles--;
            end
            else
                tokens_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((chars_if.valid && chars_if.ready) || (tokens_if.valid && tokens_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= '0;
        chars_if.valid         <= 1'b0;
        chars_if.character     <= '0;
        chars_if.end_of_source <= 1'b0;
        hold_cycles   = 0;
        send_idle_pct = 18;
        recv_idle_pct = 60;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("if(x==9){print}else=;+\n");
        send_char(8'h00, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'hFF, 1'b1);
        settle();

        write_limit(16'd0);
        hold_cycles = 300;
        send_random(150);
        settle();

        send_idle_pct = 60;
        recv_idle_pct = 18;
        write_limit(lexer.emitted + 16'd20);
        send_random(300);
        settle();

        write_limit(16'hFFFF);
        send_random(200);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(lexer.emitted + 16'($urandom_range(5, 60)));
        send_random(350);
        send_char(rand_letter(), 1'b0);
        repeat (30) send_char(rand_alnum(), 1'b0);
        repeat (3) send_char(CH_NEWLINE, 1'b0);
        send_text("x;");
        send_char(CH_RBRACE, 1'b1);
        settle();
        repeat (10) @(posedge clk);

        if (lexer.errors == 0 && lexer.expected_tokens.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
